[rtl/core/cbe_pkg.sv]
// Shared widths, fixed-point constants and stage payload types of the Bezier evaluator.
`timescale 1ns / 1ps

package cbe_pkg;

    // Coordinate and parameter formats
    localparam int CoordBits = 16;
    localparam int FracBits  = 16;
    localparam int ParamW    = FracBits + 1;
    localparam int NumPts    = 4;
    localparam int NumAxes   = 3;
    localparam int CfgW      = NumAxes * CoordBits;
    localparam int CfgIdxW   = $clog2(NumPts);

    // Result field widths
    localparam int PosW = CoordBits;
    localparam int VelW = CoordBits + 3;
    localparam int AccW = CoordBits + 5;

    // Basis weights may carry one guard bit above 1.0
    localparam int BasisW   = ParamW + 1;
    // 3*d and 6*d of one coordinate difference
    localparam int VelCoefW = CoordBits + 4;
    // 6*(second difference)
    localparam int AccCoefW = CoordBits + 5;

    localparam logic [ParamW-1:0] ParamOne = {1'b1, {FracBits{1'b0}}};

    // Powers of t and 1-t leaving the basis pipeline
    typedef struct packed {
        logic [BasisW-1:0] b0;
        logic [BasisW-1:0] b1;
        logic [BasisW-1:0] b2;
        logic [BasisW-1:0] b3;
        logic [ParamW-1:0] u2;
        logic [ParamW-1:0] ut;
        logic [ParamW-1:0] t2;
        logic [ParamW-1:0] u;
        logic [ParamW-1:0] t;
    } t_basis;

    // Per-axis control points and pre-scaled differences
    typedef struct packed {
        logic signed [CoordBits-1:0] p0;
        logic signed [CoordBits-1:0] p1;
        logic signed [CoordBits-1:0] p2;
        logic signed [CoordBits-1:0] p3;
        logic signed [VelCoefW-1:0]  v10;
        logic signed [VelCoefW-1:0]  v21;
        logic signed [VelCoefW-1:0]  v32;
        logic signed [AccCoefW-1:0]  a0;
        logic signed [AccCoefW-1:0]  a1;
    } t_axis_coef;

endpackage

[rtl/core/cubic_bezier_evaluator_unit.sv]
// Cubic Bezier evaluator: position, first and second derivative of a 3D curve per parameter.
// A beat taken on start passes three basis stages, one product stage and one sum stage
// before it shows on the result ports with o_valid high.
// Throughput: one beat per clock, set by the fully pipelined multiplier stages; busy stays low.
// Reset (synchronous, active low) clears the valid pipeline and all control points to zero.
// Results are strobed for one cycle and cannot be held off by the receiver.
`timescale 1ns / 1ps

module cubic_bezier_evaluator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cbe_pkg::ParamW-1:0]          i_curve_param,
    input  logic                                i_cfg_we,
    input  logic [cbe_pkg::CfgIdxW-1:0]         i_cfg_idx,
    input  logic [cbe_pkg::CfgW-1:0]            i_cfg_wdata,
    output logic                                o_valid,
    output logic signed [cbe_pkg::PosW-1:0]     o_pos_x,
    output logic signed [cbe_pkg::PosW-1:0]     o_pos_y,
    output logic signed [cbe_pkg::PosW-1:0]     o_pos_z,
    output logic signed [cbe_pkg::VelW-1:0]     o_vel_x,
    output logic signed [cbe_pkg::VelW-1:0]     o_vel_y,
    output logic signed [cbe_pkg::VelW-1:0]     o_vel_z,
    output logic signed [cbe_pkg::AccW-1:0]     o_acc_x,
    output logic signed [cbe_pkg::AccW-1:0]     o_acc_y,
    output logic signed [cbe_pkg::AccW-1:0]     o_acc_z
);
    import cbe_pkg::*;

    t_axis_coef [NumAxes-1:0] coef;
    t_basis                   basis;
    logic                     basis_valid;
    logic                     r_v3, r_v4;

    // The pipeline takes a beat every cycle
    assign busy = 1'b0;

    cbe_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_coef      (coef)
    );

    cbe_basis u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_param (i_curve_param),
        .o_valid (basis_valid),
        .o_basis (basis)
    );

    cbe_axis u_axis_x (
        .i_clk   (i_clk),
        .i_basis (basis),
        .i_coef  (coef[0]),
        .o_pos   (o_pos_x),
        .o_vel   (o_vel_x),
        .o_acc   (o_acc_x)
    );

    cbe_axis u_axis_y (
        .i_clk   (i_clk),
        .i_basis (basis),
        .i_coef  (coef[1]),
        .o_pos   (o_pos_y),
        .o_vel   (o_vel_y),
        .o_acc   (o_acc_y)
    );

    cbe_axis u_axis_z (
        .i_clk   (i_clk),
        .i_basis (basis),
        .i_coef  (coef[2]),
        .o_pos   (o_pos_z),
        .o_vel   (o_vel_z),
        .o_acc   (o_acc_z)
    );

    // Carry valid alongside the product and sum stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v3 <= basis_valid;
            r_v4 <= r_v3;
        end
    end

    assign o_valid = r_v4;

    // Every result strobe traces back to an accepted beat through the basis, product and sum stages
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 5))
        else $error("result strobe without a matching accepted beat");

endmodule

[rtl/core/cbe_cfg_regs.sv]
// Control-point registers and the per-axis difference coefficients derived from them.
`timescale 1ns / 1ps

module cbe_cfg_regs (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_we,
    input  logic [cbe_pkg::CfgIdxW-1:0]                  i_cfg_idx,
    input  logic [cbe_pkg::CfgW-1:0]                     i_cfg_wdata,
    output cbe_pkg::t_axis_coef [cbe_pkg::NumAxes-1:0]   o_coef
);
    import cbe_pkg::*;

    logic [CfgW-1:0]              r_ctrl [NumPts];
    t_axis_coef [NumAxes-1:0]     r_coef;
    t_axis_coef [NumAxes-1:0]     n_coef;

    // Write one control point per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumPts; k++) begin
                r_ctrl[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_ctrl[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    // Form differences per axis; the user must only move these between items, the block does not enforce it
    always_comb begin
        logic signed [CoordBits-1:0] p0, p1, p2, p3;
        logic signed [CoordBits:0]   d10, d21, d32;
        logic signed [CoordBits+1:0] s0, s1;
        for (int a = 0; a < NumAxes; a++) begin
            p0  = r_ctrl[0][a*CoordBits +: CoordBits];
            p1  = r_ctrl[1][a*CoordBits +: CoordBits];
            p2  = r_ctrl[2][a*CoordBits +: CoordBits];
            p3  = r_ctrl[3][a*CoordBits +: CoordBits];
            d10 = (CoordBits+1)'(p1) - (CoordBits+1)'(p0);
            d21 = (CoordBits+1)'(p2) - (CoordBits+1)'(p1);
            d32 = (CoordBits+1)'(p3) - (CoordBits+1)'(p2);
            s0  = (CoordBits+2)'(p2) - ((CoordBits+2)'(p1) <<< 1) + (CoordBits+2)'(p0);
            s1  = (CoordBits+2)'(p3) - ((CoordBits+2)'(p2) <<< 1) + (CoordBits+2)'(p1);
            n_coef[a].p0  = p0;
            n_coef[a].p1  = p1;
            n_coef[a].p2  = p2;
            n_coef[a].p3  = p3;
            n_coef[a].v10 = (VelCoefW'(d10) <<< 1) + VelCoefW'(d10);
            n_coef[a].v21 = (VelCoefW'(d21) <<< 2) + (VelCoefW'(d21) <<< 1);
            n_coef[a].v32 = (VelCoefW'(d32) <<< 1) + VelCoefW'(d32);
            n_coef[a].a0  = (AccCoefW'(s0) <<< 2) + (AccCoefW'(s0) <<< 1);
            n_coef[a].a1  = (AccCoefW'(s1) <<< 2) + (AccCoefW'(s1) <<< 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
    end

    assign o_coef = r_coef;

endmodule

[rtl/core/cbe_basis.sv]
// Three-stage pipeline from the curve parameter to the Bernstein weights and powers of t.
`timescale 1ns / 1ps

module cbe_basis (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [cbe_pkg::ParamW-1:0]    i_param,
    output logic                          o_valid,
    output cbe_pkg::t_basis               o_basis
);
    import cbe_pkg::*;

    localparam int ProdW = 2 * ParamW;

    // Stage 0: clamped t and 1-t
    logic              r_v0, r_v1, r_v2;
    logic [ParamW-1:0] r_t0, r_u0, n_t0;
    // Stage 1: second-order powers
    logic [ParamW-1:0] r_t1, r_u1, r_u2_1, r_t2_1, r_ut1;
    logic [ProdW-1:0]  m_uu, m_tt, m_ut;
    // Stage 2: third-order weights
    logic [ProdW-1:0]  m_b0, m_b1, m_b2, m_b3;
    logic [ProdW+1:0]  m_b1x3, m_b2x3;
    t_basis            r_basis, n_basis;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // Clamp t to one
    assign n_t0 = (i_param > ParamOne) ? ParamOne : i_param;

    always_ff @(posedge i_clk) begin
        r_t0 <= n_t0;
        r_u0 <= ParamOne - n_t0;
    end

    // Second-order products, truncated to the parameter scale
    assign m_uu = r_u0 * r_u0;
    assign m_tt = r_t0 * r_t0;
    assign m_ut = r_u0 * r_t0;

    always_ff @(posedge i_clk) begin
        r_t1   <= r_t0;
        r_u1   <= r_u0;
        r_u2_1 <= m_uu[FracBits +: ParamW];
        r_t2_1 <= m_tt[FracBits +: ParamW];
        r_ut1  <= m_ut[FracBits +: ParamW];
    end

    // Cubic weights; the middle two carry the factor three as a shift-add
    assign m_b0   = r_u2_1 * r_u1;
    assign m_b1   = r_u2_1 * r_t1;
    assign m_b2   = r_t2_1 * r_u1;
    assign m_b3   = r_t2_1 * r_t1;
    assign m_b1x3 = {2'b00, m_b1} + {1'b0, m_b1, 1'b0};
    assign m_b2x3 = {2'b00, m_b2} + {1'b0, m_b2, 1'b0};

    always_comb begin
        n_basis.b0 = {1'b0, m_b0[FracBits +: ParamW]};
        n_basis.b1 = m_b1x3[FracBits +: BasisW];
        n_basis.b2 = m_b2x3[FracBits +: BasisW];
        n_basis.b3 = {1'b0, m_b3[FracBits +: ParamW]};
        n_basis.u2 = r_u2_1;
        n_basis.ut = r_ut1;
        n_basis.t2 = r_t2_1;
        n_basis.u  = r_u1;
        n_basis.t  = r_t1;
    end

    always_ff @(posedge i_clk) begin
        r_basis <= n_basis;
    end

    assign o_valid = r_v2;
    assign o_basis = r_basis;

    // t and 1-t always add up to one after the clamp
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 |-> ({1'b0, r_t0} + {1'b0, r_u0} == {1'b0, ParamOne}))
        else $error("t and 1-t do not sum to one");

    // The cross term never exceeds either factor
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_ut1 <= r_u1 && r_ut1 <= r_t1))
        else $error("u*t exceeds one of its factors");

    // t^3 never exceeds t^2 it was built from
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_basis.b3 <= {1'b0, r_basis.t2}))
        else $error("t^3 weight exceeds t^2");

endmodule

[rtl/core/cbe_axis.sv]
// Two-stage datapath of one axis: weighted products, then sums, floor shift and saturation.
`timescale 1ns / 1ps

module cbe_axis (
    input  logic                                  i_clk,
    input  cbe_pkg::t_basis                       i_basis,
    input  cbe_pkg::t_axis_coef                   i_coef,
    output logic signed [cbe_pkg::PosW-1:0]       o_pos,
    output logic signed [cbe_pkg::VelW-1:0]       o_vel,
    output logic signed [cbe_pkg::AccW-1:0]       o_acc
);
    import cbe_pkg::*;

    localparam int PosProdW = BasisW + 1 + CoordBits;
    localparam int VelProdW = ParamW + 1 + VelCoefW;
    localparam int AccProdW = ParamW + 1 + AccCoefW;
    localparam int SumW     = AccProdW + 2;
    localparam int ShW      = SumW - FracBits;

    logic signed [PosProdW-1:0] m_pos [4];
    logic signed [VelProdW-1:0] m_vel [3];
    logic signed [AccProdW-1:0] m_acc [2];
    logic signed [PosProdW-1:0] r_pos_term [4];
    logic signed [VelProdW-1:0] r_vel_term [3];
    logic signed [AccProdW-1:0] r_acc_term [2];
    logic signed [SumW-1:0]     sum_pos, sum_vel, sum_acc;
    logic signed [ShW-1:0]      n_pos, n_vel, n_acc;
    logic signed [PosW-1:0]     r_pos;
    logic signed [VelW-1:0]     r_vel;
    logic signed [AccW-1:0]     r_acc;

    // Clip a shifted sum to a signed field of the given width
    function automatic logic signed [ShW-1:0] sat_sh(input logic signed [ShW-1:0] v,
                                                     input int unsigned bits);
        logic signed [ShW-1:0] hi;
        logic signed [ShW-1:0] lo;
        hi = (ShW'(1) <<< (bits - 1)) - ShW'(1);
        lo = ~hi;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // Stage 3: one product per term
    assign m_pos[0] = $signed({1'b0, i_basis.b0}) * i_coef.p0;
    assign m_pos[1] = $signed({1'b0, i_basis.b1}) * i_coef.p1;
    assign m_pos[2] = $signed({1'b0, i_basis.b2}) * i_coef.p2;
    assign m_pos[3] = $signed({1'b0, i_basis.b3}) * i_coef.p3;
    assign m_vel[0] = $signed({1'b0, i_basis.u2}) * i_coef.v10;
    assign m_vel[1] = $signed({1'b0, i_basis.ut}) * i_coef.v21;
    assign m_vel[2] = $signed({1'b0, i_basis.t2}) * i_coef.v32;
    assign m_acc[0] = $signed({1'b0, i_basis.u}) * i_coef.a0;
    assign m_acc[1] = $signed({1'b0, i_basis.t}) * i_coef.a1;

    always_ff @(posedge i_clk) begin
        r_pos_term <= m_pos;
        r_vel_term <= m_vel;
        r_acc_term <= m_acc;
    end

    // Stage 4: add terms, drop the fraction toward minus infinity
    assign sum_pos = SumW'(r_pos_term[0]) + SumW'(r_pos_term[1])
                   + SumW'(r_pos_term[2]) + SumW'(r_pos_term[3]);
    assign sum_vel = SumW'(r_vel_term[0]) + SumW'(r_vel_term[1]) + SumW'(r_vel_term[2]);
    assign sum_acc = SumW'(r_acc_term[0]) + SumW'(r_acc_term[1]);

    assign n_pos = sat_sh(sum_pos[SumW-1:FracBits], PosW);
    assign n_vel = sat_sh(sum_vel[SumW-1:FracBits], VelW);
    assign n_acc = sat_sh(sum_acc[SumW-1:FracBits], AccW);

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos[PosW-1:0];
        r_vel <= n_vel[VelW-1:0];
        r_acc <= n_acc[AccW-1:0];
    end

    assign o_pos = r_pos;
    assign o_vel = r_vel;
    assign o_acc = r_acc;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the cubic Bezier evaluator unit.
`timescale 1ns / 1ps

module tb;
    import cbe_pkg::*;

    // Control point register map
    typedef enum logic [CfgIdxW-1:0] {
        REG_P0 = 0,
        REG_P1 = 1,
        REG_P2 = 2,
        REG_P3 = 3
    } t_pt_reg;

    // One curve sample as the block returns it
    typedef struct {
        logic signed [PosW-1:0] pos [NumAxes];
        logic signed [VelW-1:0] vel [NumAxes];
        logic signed [AccW-1:0] acc [NumAxes];
    } t_curve_sample;

    // Shadow control points, sample predictor and queue of samples owed by the block
    class curve_sample_board;
        longint        pts [NumPts][NumAxes];
        t_curve_sample owed_samples [$];
        int            n_err;

        function new();
            foreach (pts[i, a]) pts[i][a] = 0;
            n_err = 0;
        endfunction

        // Unpack x, y, z of one written point
        function void set_point(t_pt_reg idx, logic [CfgW-1:0] data);
            for (int a = 0; a < NumAxes; a++)
                pts[idx][a] = longint'($signed(data[a*CoordBits +: CoordBits]));
        endfunction

        function longint clip(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // Position and both derivatives at parameter t, floor-truncated
        function t_curve_sample eval_curve(logic [ParamW-1:0] t_raw);
            t_curve_sample s;
            longint t, u, u2, t2, ut, b0, b1, b2, b3, p0, p1, p2, p3, pos, vel, acc;
            t = (t_raw > ParamOne) ? longint'(ParamOne) : longint'(t_raw);
            u = longint'(ParamOne) - t;
            u2 = (u * u) >>> FracBits;
            t2 = (t * t) >>> FracBits;
            ut = (u * t) >>> FracBits;
            b0 = (u2 * u) >>> FracBits;
            b1 = (3 * u2 * t) >>> FracBits;
            b2 = (3 * t2 * u) >>> FracBits;
            b3 = (t2 * t) >>> FracBits;
            for (int a = 0; a < NumAxes; a++) begin
                p0 = pts[0][a];
                p1 = pts[1][a];
                p2 = pts[2][a];
                p3 = pts[3][a];
                pos = b0 * p0 + b1 * p1 + b2 * p2 + b3 * p3;
                vel = 3 * u2 * (p1 - p0) + 6 * ut * (p2 - p1) + 3 * t2 * (p3 - p2);
                acc = 6 * u * (p2 - 2 * p1 + p0) + 6 * t * (p3 - 2 * p2 + p1);
                s.pos[a] = PosW'(clip(pos >>> FracBits, PosW));
                s.vel[a] = VelW'(clip(vel >>> FracBits, VelW));
                s.acc[a] = AccW'(clip(acc >>> FracBits, AccW));
            end
            return s;
        endfunction

        function void note_param(logic [ParamW-1:0] t);
            owed_samples.insert(owed_samples.size(), eval_curve(t));
        endfunction

        function int owed();
            return owed_samples.size();
        endfunction

        function void cmp(string name, longint want, logic signed [AccW-1:0] got);
            if (got !== want[AccW-1:0]) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                n_err++;
            end
        endfunction

        // Compare one returned sample against the oldest one owed
        function void check_sample(t_curve_sample got);
            t_curve_sample want;
            string axis;
            if (owed_samples.size() == 0) begin
                $error("sample returned with none owed");
                n_err++;
                return;
            end
            want = owed_samples.pop_front();
            for (int a = 0; a < NumAxes; a++) begin
                axis = (a == 0) ? "x" : (a == 1) ? "y" : "z";
                cmp({"pos_", axis}, longint'(want.pos[a]), AccW'(got.pos[a]));
                cmp({"vel_", axis}, longint'(want.vel[a]), AccW'(got.vel[a]));
                cmp({"acc_", axis}, longint'(want.acc[a]), got.acc[a]);
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [ParamW-1:0]      i_curve_param;
    logic                   i_cfg_we;
    logic [CfgIdxW-1:0]     i_cfg_idx;
    logic [CfgW-1:0]        i_cfg_wdata;
    logic                   o_valid;
    logic signed [PosW-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [VelW-1:0] o_vel_x, o_vel_y, o_vel_z;
    logic signed [AccW-1:0] o_acc_x, o_acc_y, o_acc_z;

    curve_sample_board board;

    cubic_bezier_evaluator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_curve_param (i_curve_param),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_vel_x       (o_vel_x),
        .o_vel_y       (o_vel_y),
        .o_vel_z       (o_vel_z),
        .o_acc_x       (o_acc_x),
        .o_acc_y       (o_acc_y),
        .o_acc_z       (o_acc_z)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Capture every strobed result beat
    always @(posedge i_clk) begin : result_mon
        t_curve_sample got;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            got.pos[0] = o_pos_x;
            got.pos[1] = o_pos_y;
            got.pos[2] = o_pos_z;
            got.vel[0] = o_vel_x;
            got.vel[1] = o_vel_y;
            got.vel[2] = o_vel_z;
            got.acc[0] = o_acc_x;
            got.acc[1] = o_acc_y;
            got.acc[2] = o_acc_z;
            board.check_sample(got);
        end
    end

    function automatic logic [CfgW-1:0] pack_point(logic [CoordBits-1:0] x,
                                                   logic [CoordBits-1:0] y,
                                                   logic [CoordBits-1:0] z);
        return {z, y, x};
    endfunction

    // Favor the coordinate extremes, otherwise full range or near zero
    function automatic logic [CoordBits-1:0] rand_coord(bit near_zero);
        if (near_zero)
            return CoordBits'($urandom_range(0, 511) - 256);
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return CoordBits'($urandom);
        endcase
    endfunction

    function automatic logic [CfgW-1:0] rand_point(bit near_zero);
        return pack_point(rand_coord(near_zero), rand_coord(near_zero), rand_coord(near_zero));
    endfunction

    // Mostly in [0, 1], with endpoints and over-range values mixed in
    function automatic logic [ParamW-1:0] rand_param();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? ParamOne : '0;
            1: return ParamW'($urandom_range(int'(ParamOne) + 1, (1 << ParamW) - 1));
            2: return ParamW'($urandom);
            default: return ParamW'($urandom_range(0, int'(ParamOne)));
        endcase
    endfunction

    // Write all four control points, shadowing each as it lands
    task automatic write_curve(input logic [CfgW-1:0] p0, input logic [CfgW-1:0] p1,
                               input logic [CfgW-1:0] p2, input logic [CfgW-1:0] p3);
        logic [CfgW-1:0] vals [NumPts];
        vals = '{p0, p1, p2, p3};
        for (int i = 0; i < NumPts; i++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= t_pt_reg'(i);
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            board.set_point(t_pt_reg'(i), vals[i]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one parameter beat until the block takes it, idling at random
    task automatic send_param(input logic [ParamW-1:0] t, input bit may_idle);
        bit taken;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            if (may_idle && $urandom_range(0, 99) < 34) begin
                start <= 1'b0;
            end else begin
                start         <= 1'b1;
                i_curve_param <= t;
                @(posedge i_clk);
                if (!busy) begin
                    taken = 1'b1;
                    board.note_param(t);
                end
            end
        end
    endtask

    // Hold off until every owed sample is back, then let the pipe settle
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.owed() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic [ParamW-1:0] directed [$];
        board         = new();
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_curve_param = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_P0;
        i_cfg_wdata   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset curve: all points at the origin
        send_param('0, 1'b0);
        send_param(ParamOne, 1'b0);
        drain();

        // Zigzag extremes drive the widest derivatives
        write_curve(pack_point(16'h7FFF, 16'h8000, 16'h7FFF),
                    pack_point(16'h8000, 16'h7FFF, 16'h8000),
                    pack_point(16'h7FFF, 16'h8000, 16'h0001),
                    pack_point(16'h8000, 16'h7FFF, 16'hFFFF));
        directed = '{17'h00000, 17'h00001, 17'h0FFFF, 17'h10000, 17'h10001, 17'h1FFFF,
                     17'h08000, 17'h04000, 17'h0C000, 17'h15555, 17'h0AAAA, 17'h05555,
                     17'h00100, 17'h0FF00, 17'h18000, 17'h00002};
        foreach (directed[i])
            send_param(directed[i], 1'b0);
        drain();

        // Flat curves at each coordinate extreme
        write_curve(pack_point(16'h7FFF, 16'h7FFF, 16'h7FFF),
                    pack_point(16'h7FFF, 16'h7FFF, 16'h7FFF),
                    pack_point(16'h7FFF, 16'h7FFF, 16'h7FFF),
                    pack_point(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_param('0, 1'b0);
        send_param(17'h08000, 1'b0);
        send_param(ParamOne, 1'b0);
        drain();
        write_curve(pack_point(16'h8000, 16'h8000, 16'h8000),
                    pack_point(16'h8000, 16'h8000, 16'h8000),
                    pack_point(16'h8000, 16'h8000, 16'h8000),
                    pack_point(16'h8000, 16'h8000, 16'h8000));
        send_param('0, 1'b0);
        send_param(17'h0AAAA, 1'b0);
        send_param(17'h1FFFF, 1'b0);
        drain();

        // Random phases; phase 2 streams back to back, phase 3 keeps points small
        for (int ph = 0; ph < 5; ph++) begin
            write_curve(rand_point(ph == 3), rand_point(ph == 3),
                        rand_point(ph == 3), rand_point(ph == 3));
            for (int k = 0; k < 100; k++) begin
                send_param(rand_param(), ph != 2);
                if (ph == 1 && k == 50)
                    drain();
            end
            drain();
        end

        if (board.n_err == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Stop a hung run
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
